// ===== rtl/alr_pkg.sv =====
// Shared types, constants and codes for the anti-aliased line rasteriser.
package alr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 2048;
  localparam int COORD_W   = 12;
  localparam int DIM_W     = 12;
  localparam int INDEX_W   = 22;
  localparam int ACC_W     = 30;
  localparam int SLOPE_W   = 18;
  localparam int QUOT_W    = FRAC_BITS + 1;
  localparam int DIV_STEPS = QUOT_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] HALF_ALPHA = 8'((255 * (1 << (FRAC_BITS - 1))) >> FRAC_BITS);
  localparam logic [DIM_W-1:0] DIM_RESET   = DIM_W'(1024);
  localparam logic [DIM_W-1:0] MAX_DIM_VAL = DIM_W'(MAX_DIM);

  localparam logic REQ_NEW     = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [7:0]                red_in;
    logic [7:0]                green_in;
    logic [7:0]                blue_in;
  } req_t;

  typedef struct packed {
    logic               near_valid;
    logic [INDEX_W-1:0] near_index;
    logic [7:0]         near_alpha;
    logic               far_valid;
    logic [INDEX_W-1:0] far_index;
    logic [7:0]         far_alpha;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic               line_done;
  } pix_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FIRST
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_first;
    logic emit_first;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

// ===== rtl/antialiased_line_rasterizer.sv =====
// Top level of the anti-aliased line rasteriser.
// Each request yields one column of up to two pixel writes on pix_data. A new-line request
// runs the serial restoring divider that forms the Q16 gradient and then forms its
// first-endpoint column, which is registered onto pix_data; no request is taken until that
// column is issued. Advance requests produce one column each and can be taken every cycle
// while the output is not stalled. A request is taken only when the output register is empty
// or its column leaves in the same cycle, so a stalled column holds off the next request. An
// advance while no line is active yields nothing. Canvas size registers are written through
// the cfg port (index 0 width, 1 height) and apply from the next column.
module antialiased_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  alr_pkg::req_t                  req_data,
  output logic                           pix_valid,
  input  logic                           pix_stall,
  output alr_pkg::pix_t                  pix_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [alr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alr_pkg::DIM_W-1:0]      cfg_data
);
  import alr_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;
  assign pix_valid = status.out_full;

  alr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req_data.req_type),
    .req_stall (req_stall),
    .pix_stall (pix_stall),
    .status    (status),
    .cmd       (cmd)
  );

  alr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .req_data  (req_data),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== rtl/alr_ctrl.sv =====
// Request sequencer: accepts requests, runs the gradient division, issues emits.
module alr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_type,
  output logic            req_stall,
  input  logic            pix_stall,
  input  alr_pkg::status_t status,
  output alr_pkg::cmd_t    cmd
);
  import alr_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_count;
  logic                 out_free;
  logic                 accept;
  logic                 div_last;

  assign out_free = !status.out_full || !pix_stall;
  assign accept   = req_valid && !req_stall;
  assign div_last = div_count == DIV_CNT_W'(DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_count <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        div_count <= '0;
      end else if (cmd.div_step) begin
        div_count <= div_count + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && req_type == REQ_NEW) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_last) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall      = !(state == ST_IDLE && out_free);
    cmd            = '0;
    cmd.load       = accept && req_type == REQ_NEW;
    cmd.advance    = accept && req_type == REQ_ADVANCE;
    cmd.div_step   = state == ST_DIVIDE;
    cmd.div_first  = div_count == '0;
    cmd.emit_first = state == ST_FIRST && out_free;
  end

endmodule

// ===== rtl/alr_datapath.sv =====
// Line set-up, serial gradient divider, column stepping, pixel placement, output register.
module alr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  alr_pkg::cmd_t                   cmd,
  output alr_pkg::status_t                status,
  input  alr_pkg::req_t                   req_data,
  input  logic                            pix_stall,
  output alr_pkg::pix_t                   pix_data,
  input  logic                            cfg_valid,
  input  logic [alr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alr_pkg::DIM_W-1:0]       cfg_data
);
  import alr_pkg::*;

  // configuration
  logic [DIM_W-1:0] canvas_width;
  logic [DIM_W-1:0] canvas_height;

  // line state
  logic                      steep_flag;
  logic                      line_active;
  logic signed [COORD_W:0]   current_column;
  logic signed [COORD_W-1:0] last_column;
  logic signed [COORD_W-1:0] start_row;
  logic signed [COORD_W-1:0] end_row;
  logic signed [ACC_W-1:0]   row_accumulator;
  logic signed [SLOPE_W-1:0] slope;
  logic [23:0]               colour_store;

  // divider
  logic [COORD_W-1:0] div_divisor;
  logic [COORD_W:0]   div_rem;
  logic [QUOT_W-1:0]  div_quot;
  logic               div_neg;
  logic               div_zero;

  logic out_full;

  // set-up
  logic signed [COORD_W:0] x1, y1, x2, y2, adx, ady;
  logic signed [COORD_W:0] a1, b1, a2, b2, c1, r1, c2, r2, dx, dy, dy_mag;
  logic                    steep;
  logic                    swap;

  always_comb begin
    x1    = {req_data.start_x[COORD_W-1], req_data.start_x};
    y1    = {req_data.start_y[COORD_W-1], req_data.start_y};
    x2    = {req_data.end_x[COORD_W-1], req_data.end_x};
    y2    = {req_data.end_y[COORD_W-1], req_data.end_y};
    adx   = (x2 > x1) ? x2 - x1 : x1 - x2;
    ady   = (y2 > y1) ? y2 - y1 : y1 - y2;
    steep = ady > adx;
    a1    = steep ? y1 : x1;
    b1    = steep ? x1 : y1;
    a2    = steep ? y2 : x2;
    b2    = steep ? x2 : y2;
    swap  = a1 > a2;
    c1    = swap ? a2 : a1;
    r1    = swap ? b2 : b1;
    c2    = swap ? a1 : a2;
    r2    = swap ? b1 : b2;
    dx    = c2 - c1;
    dy    = r2 - r1;
    dy_mag = dy[COORD_W] ? -dy : dy;
  end

  // restoring division step: |dy| * 2^FRAC_BITS / dx
  logic [COORD_W+1:0] div_trial;
  logic               div_ge;
  logic [COORD_W+1:0] div_diff;

  assign div_trial = cmd.div_first ? {1'b0, div_rem} : {div_rem, 1'b0};
  assign div_ge    = div_trial >= {2'b00, div_divisor};
  assign div_diff  = div_trial - {2'b00, div_divisor};

  logic [SLOPE_W-1:0] quot_ext;
  logic [SLOPE_W-1:0] slope_val;

  always_comb begin
    quot_ext = {{(SLOPE_W-QUOT_W){1'b0}}, div_quot};
    if (div_zero) begin
      slope_val = {{(SLOPE_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    end else if (div_neg) begin
      slope_val = '0 - quot_ext;
    end else begin
      slope_val = quot_ext;
    end
  end

  logic [ACC_W-1:0] acc_start;
  logic [ACC_W-1:0] slope_ext;

  assign acc_start = {{(ACC_W-COORD_W-FRAC_BITS){start_row[COORD_W-1]}}, start_row,
                      {FRAC_BITS{1'b0}}};
  assign slope_ext = {{(ACC_W-SLOPE_W){slope[SLOPE_W-1]}}, slope};

  // column selection
  logic                    interior;
  logic signed [COORD_W:0] col_sel;
  logic signed [COORD_W:0] row_sel;
  logic signed [COORD_W:0] row_far;
  logic [7:0]              na_sel;
  logic [7:0]              fa_sel;
  logic                    done_sel;
  logic [FRAC_BITS-1:0]    frac;
  logic [FRAC_BITS:0]      inv_frac;
  logic [FRAC_BITS+8:0]    na_prod;
  logic [FRAC_BITS+7:0]    fa_prod;

  assign interior = current_column < $signed({last_column[COORD_W-1], last_column});
  assign frac     = row_accumulator[FRAC_BITS-1:0];
  assign inv_frac = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
  assign na_prod  = {inv_frac, 8'b0} - {8'b0, inv_frac};
  assign fa_prod  = {frac, 8'b0} - {8'b0, frac};

  always_comb begin
    if (cmd.emit_first) begin
      col_sel  = current_column;
      row_sel  = {start_row[COORD_W-1], start_row};
      na_sel   = HALF_ALPHA;
      fa_sel   = '0;
      done_sel = 1'b0;
    end else if (interior) begin
      col_sel  = current_column;
      row_sel  = row_accumulator[FRAC_BITS+COORD_W:FRAC_BITS];
      na_sel   = na_prod[FRAC_BITS+7:FRAC_BITS];
      fa_sel   = fa_prod[FRAC_BITS+7:FRAC_BITS];
      done_sel = 1'b0;
    end else begin
      col_sel  = {last_column[COORD_W-1], last_column};
      row_sel  = {end_row[COORD_W-1], end_row};
      na_sel   = HALF_ALPHA;
      fa_sel   = '0;
      done_sel = 1'b1;
    end
    row_far = row_sel + 1'b1;
  end

  // placement
  logic [DIM_W-1:0]          w_eff;
  logic [DIM_W-1:0]          h_eff;
  logic [DIM_W-2:0]          ox;
  logic [DIM_W-2:0]          oy;
  logic signed [COORD_W:0]   near_px, near_py, far_px, far_py;
  logic signed [COORD_W+1:0] sx, sy;
  logic signed [26:0]        prod;
  logic [27:0]               near_raw;
  logic [INDEX_W-1:0]        far_raw;
  logic                      near_ok;
  logic                      far_ok;

  function automatic logic on_canvas(input logic signed [COORD_W:0] px,
                                     input logic signed [COORD_W:0] py,
                                     input logic [DIM_W-2:0] hx,
                                     input logic [DIM_W-2:0] hy);
    logic signed [COORD_W+1:0] px14, py14, hx14, hy14;
    px14 = {px[COORD_W], px};
    py14 = {py[COORD_W], py};
    hx14 = {3'b000, hx};
    hy14 = {3'b000, hy};
    return (px14 >= -hx14) && (px14 < hx14) && (py14 >= -hy14) && (py14 < hy14);
  endfunction

  always_comb begin
    w_eff   = (canvas_width > MAX_DIM_VAL) ? MAX_DIM_VAL : canvas_width;
    h_eff   = (canvas_height > MAX_DIM_VAL) ? MAX_DIM_VAL : canvas_height;
    ox      = w_eff[DIM_W-1:1];
    oy      = h_eff[DIM_W-1:1];
    near_px = steep_flag ? row_sel : col_sel;
    near_py = steep_flag ? col_sel : row_sel;
    far_px  = steep_flag ? row_far : col_sel;
    far_py  = steep_flag ? col_sel : row_far;
    near_ok = on_canvas(near_px, near_py, ox, oy);
    far_ok  = on_canvas(far_px, far_py, ox, oy);
    sx      = {near_px[COORD_W], near_px} + {3'b000, ox};
    sy      = {near_py[COORD_W], near_py} + {3'b000, oy};
    prod    = sy * $signed({1'b0, w_eff});
    near_raw = {prod[26], prod} + {{14{sx[COORD_W+1]}}, sx};
    far_raw  = near_raw[INDEX_W-1:0] +
               (steep_flag ? INDEX_W'(1) : {{(INDEX_W-DIM_W){1'b0}}, w_eff});
  end

  logic emit;
  assign emit = cmd.emit_first || (cmd.advance && line_active);

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= DIM_RESET;
      canvas_height <= DIM_RESET;
      line_active   <= 1'b0;
      steep_flag    <= 1'b0;
      out_full      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
          REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        steep_flag  <= steep;
        line_active <= 1'b1;
      end else if (cmd.advance && line_active && !interior) begin
        line_active <= 1'b0;
      end
      out_full <= emit || (out_full && pix_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      current_column <= c1;
      last_column    <= c2[COORD_W-1:0];
      start_row      <= r1[COORD_W-1:0];
      end_row        <= r2[COORD_W-1:0];
      div_divisor    <= dx[COORD_W-1:0];
      div_rem        <= {1'b0, dy_mag[COORD_W-1:0]};
      div_neg        <= dy[COORD_W];
      div_zero       <= dx == '0;
      colour_store   <= {req_data.red_in, req_data.green_in, req_data.blue_in};
    end
    if (cmd.div_step) begin
      div_rem  <= div_ge ? div_diff[COORD_W:0] : div_trial[COORD_W:0];
      div_quot <= {div_quot[QUOT_W-2:0], div_ge};
    end
    if (cmd.emit_first) begin
      slope           <= slope_val;
      row_accumulator <= acc_start + {{(ACC_W-SLOPE_W){slope_val[SLOPE_W-1]}}, slope_val};
      current_column  <= current_column + 1'b1;
    end else if (cmd.advance && line_active && interior) begin
      row_accumulator <= row_accumulator + slope_ext;
      current_column  <= current_column + 1'b1;
    end
    if (emit) begin
      pix_data.near_valid <= near_ok;
      pix_data.near_index <= near_ok ? near_raw[INDEX_W-1:0] : '0;
      pix_data.near_alpha <= na_sel;
      pix_data.far_valid  <= far_ok;
      pix_data.far_index  <= far_ok ? far_raw : '0;
      pix_data.far_alpha  <= fa_sel;
      pix_data.red_out    <= colour_store[23:16];
      pix_data.green_out  <= colour_store[15:8];
      pix_data.blue_out   <= colour_store[7:0];
      pix_data.line_done  <= done_sel;
    end
  end

  assign status.out_full = out_full;

endmodule

// ===== sim/tb_antialiased_line_rasterizer.sv =====
// Self-checking testbench for the anti-aliased line rasteriser over several canvas sizes.
module tb_antialiased_line_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;
  import alr_pkg::*;

  localparam longint Q_ONE       = longint'(1) << FRAC_BITS;
  localparam int     STALL_LIMIT = 2000;
  localparam int     DRAIN_WAIT  = 40;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_data  = '0;
  logic                 pix_valid;
  logic                 pix_stall = 1'b0;
  pix_t                 pix_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CANVAS_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;

  // predicted rasteriser state
  int          canvas_w = 1024;
  int          canvas_h = 1024;
  bit          steep;
  int          col_now, col_last, row_end;
  longint      row_acc, grad;
  logic [23:0] colour;
  bit          drawing;
  pix_t        column_q[$];

  int errors, n_req, n_pix, n_lines, idle_cycles;
  bit quiet;

  antialiased_line_rasterizer i_dut (
    .clk, .rst, .req_valid, .req_stall, .req_data, .pix_valid, .pix_stall, .pix_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void locate(input int px, input int py, output logic ok,
                                 output logic [INDEX_W-1:0] idx);
    int w, h, ox, oy;
    w  = (canvas_w > MAX_DIM) ? MAX_DIM : canvas_w;
    h  = (canvas_h > MAX_DIM) ? MAX_DIM : canvas_h;
    ox = w / 2;
    oy = h / 2;
    ok  = !(px < -ox || px >= ox || py < -oy || py >= oy);
    idx = ok ? INDEX_W'((py + oy) * w + px + ox) : '0;
  endfunction

  function automatic pix_t column(input int c, input int r, input logic [7:0] na,
                                  input logic [7:0] fa, input logic done);
    pix_t p;
    if (steep) begin
      locate(r, c, p.near_valid, p.near_index);
      locate(r + 1, c, p.far_valid, p.far_index);
    end else begin
      locate(c, r, p.near_valid, p.near_index);
      locate(c, r + 1, p.far_valid, p.far_index);
    end
    p.near_alpha = na;
    p.far_alpha  = fa;
    {p.red_out, p.green_out, p.blue_out} = colour;
    p.line_done  = done;
    return p;
  endfunction

  function automatic void rasterise(input req_t r);
    int     x1, y1, x2, y2, t, dx, dy, adx, ady;
    longint rowi, f;
    if (r.req_type == REQ_NEW) begin
      x1 = int'(r.start_x);
      y1 = int'(r.start_y);
      x2 = int'(r.end_x);
      y2 = int'(r.end_y);
      adx = (x2 > x1) ? x2 - x1 : x1 - x2;
      ady = (y2 > y1) ? y2 - y1 : y1 - y2;
      steep = ady > adx;
      if (steep) begin
        t = x1; x1 = y1; y1 = t;
        t = x2; x2 = y2; y2 = t;
      end
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      grad     = (dx == 0) ? Q_ONE : (longint'(dy) * Q_ONE) / dx;
      colour   = {r.red_in, r.green_in, r.blue_in};
      col_now  = x1 + 1;
      col_last = x2;
      row_end  = y2;
      row_acc  = longint'(y1) * Q_ONE + grad;
      drawing  = 1'b1;
      n_lines++;
      column_q.push_back(column(x1, y1, HALF_ALPHA, 8'd0, 1'b0));
    end else if (drawing) begin
      if (col_now < col_last) begin
        rowi = row_acc >>> FRAC_BITS;
        f    = row_acc - (rowi << FRAC_BITS);
        column_q.push_back(column(col_now, int'(rowi), 8'((255 * (Q_ONE - f)) >> FRAC_BITS),
                                  8'((255 * f) >> FRAC_BITS), 1'b0));
        row_acc += grad;
        col_now++;
      end else begin
        column_q.push_back(column(col_last, row_end, HALF_ALPHA, 8'd0, 1'b1));
        drawing = 1'b0;
      end
    end
  endfunction

  function automatic void compare(input string name, input logic [31:0] exp_v,
                                  input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    pix_t want;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        n_pix++;
        if (column_q.size() == 0) begin
          errors++;
          $error("column with no request outstanding: %p", pix_data);
        end else begin
          want = column_q.pop_front();
          compare("near_valid", want.near_valid, pix_data.near_valid);
          compare("near_index", want.near_index, pix_data.near_index);
          compare("near_alpha", want.near_alpha, pix_data.near_alpha);
          compare("far_valid", want.far_valid, pix_data.far_valid);
          compare("far_index", want.far_index, pix_data.far_index);
          compare("far_alpha", want.far_alpha, pix_data.far_alpha);
          compare("red_out", want.red_out, pix_data.red_out);
          compare("green_out", want.green_out, pix_data.green_out);
          compare("blue_out", want.blue_out, pix_data.blue_out);
          compare("line_done", want.line_done, pix_data.line_done);
        end
      end
      if (req_valid && !req_stall) begin
        n_req++;
        rasterise(req_data);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CANVAS_WIDTH) canvas_w = int'(cfg_data);
        else canvas_h = int'(cfg_data);
      end
    end
  end

  always @(posedge clk) pix_stall <= !quiet && ($urandom_range(99) < 8);

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (pix_valid && !pix_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb_antialiased_line_rasterizer failed");
      $finish;
    end
  end

  // leaves req_valid high once the request is taken
  task automatic send(input req_t r);
    while (!quiet && $urandom_range(99) < 8) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (column_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_canvas(input int w, input int h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data  <= DIM_W'(w);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data  <= DIM_W'(h);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t new_line(input int x1, input int y1, input int x2, input int y2,
                                    input logic [23:0] rgb);
    req_t r;
    r.req_type = REQ_NEW;
    r.start_x  = COORD_W'(x1);
    r.start_y  = COORD_W'(y1);
    r.end_x    = COORD_W'(x2);
    r.end_y    = COORD_W'(y2);
    {r.red_in, r.green_in, r.blue_in} = rgb;
    return r;
  endfunction

  // advance request; the other fields carry noise
  function automatic req_t step_req();
    logic [95:0] noise;
    req_t r;
    noise = {$urandom, $urandom, $urandom};
    r = noise[$bits(req_t)-1:0];
    r.req_type = REQ_ADVANCE;
    return r;
  endfunction

  function automatic int clamp_coord(input int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  function automatic int pick_coord(input int span);
    if ($urandom_range(9) < 3) return int'($urandom_range(4095)) - 2048;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // cut >= 0 abandons the line after that many advances
  task automatic draw_line(input int x1, input int y1, input int x2, input int y2,
                           input logic [23:0] rgb, input int cut, inout int sent);
    int adx, ady, steps;
    adx   = (x2 > x1) ? x2 - x1 : x1 - x2;
    ady   = (y2 > y1) ? y2 - y1 : y1 - y2;
    steps = (adx > ady) ? adx : ady;
    if (steps == 0) steps = 1;
    if (cut >= 0 && cut < steps) steps = cut;
    send(new_line(x1, y1, x2, y2, rgb));
    repeat (steps) send(step_req());
    sent += steps + 1;
  endtask

  task automatic test_field_extremes();
    int sent;
    sent = 0;
    draw_line(-2048, -2048, 2047, 2047, 24'hffffff, 2, sent);
    draw_line(2047, -2048, -2048, 2047, 24'h000000, 2, sent);
    draw_line(0, 0, 5, 2, 24'h123456, -1, sent);
    draw_line(0, 0, -2, 5, 24'ha5c3e1, -1, sent);
  endtask

  task automatic test_idle_and_degenerate();
    int sent;
    sent = 0;
    send(step_req());
    draw_line(511, 511, 511, 511, 24'h5a0ff0, -1, sent);
  endtask

  task automatic test_random_lines(input int items, input int span);
    int sent, kind, len, x1, y1, x2, y2, ddx, ddy, t;
    sent = 0;
    while (sent < items) begin
      quiet = (sent >= items / 3) && (sent < 2 * items / 3);
      kind  = $urandom_range(99);
      if (kind < 7) begin
        repeat ($urandom_range(3, 1)) send(step_req());
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(16);
        ddx = $urandom_range(1) ? len : -len;
        ddy = ($urandom_range(9) == 0) ? 0 : int'($urandom_range(2 * len)) - len;
        if ($urandom_range(1)) begin
          t = ddx; ddx = ddy; ddy = t;
        end
        x1 = pick_coord(span);
        y1 = pick_coord(span);
        x2 = clamp_coord(x1 + ddx);
        y2 = clamp_coord(y1 + ddy);
        draw_line(x1, y1, x2, y2, 24'($urandom),
                  (kind < 15) ? int'($urandom_range(len)) : -1, sent);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_canvas(input int w, input int h, input int items, input int span);
    settle();
    set_canvas(w, h);
    test_random_lines(items, span);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_field_extremes();
    test_idle_and_degenerate();
    test_random_lines(400, 600);
    test_canvas(2048, 2048, 250, 1100);
    test_canvas(2, 2, 150, 4);
    test_canvas(4095, 3, 150, 40);
    test_canvas(0, 1, 100, 8);
    test_canvas(37, 2047, 280, 60);
    settle();
    $display("Drew %0d lines from %0d requests; %0d columns checked.", n_lines, n_req, n_pix);
    $display("Canvases: default, largest, smallest, oversized, degenerate and odd sizes.");
    if (errors == 0) begin
      $display("tb_antialiased_line_rasterizer passed");
    end else begin
      $display("tb_antialiased_line_rasterizer failed");
    end
    $finish;
  end

endmodule
